// ===== rtl/core/pi_controller_remainder_divide_core_assert.svh =====
// Assertion macros for the PI controller core; empty bodies under synthesis.
`ifndef PI_CONTROLLER_REMAINDER_DIVIDE_CORE_ASSERT_SVH
`define PI_CONTROLLER_REMAINDER_DIVIDE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PIRDC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define PIRDC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PIRDC_ASSERT(label, clk, rst, prop, msg)
`define PIRDC_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/core/pirdc_pkg.sv =====
// Shared types, codes and command/status structs of the PI controller core.
`timescale 1ns / 1ps
package pirdc_pkg;

  localparam int DataW  = 32;
  localparam int RemW   = 17;
  localparam int DivW   = 16;
  localparam int StepW  = 5;
  localparam logic [StepW-1:0] DivLastStep = 5'd31;

  // Item kinds
  localparam logic [1:0] KIND_STEP   = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_PRESET = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] CFG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] CFG_OUT_MIN       = 3'd2;
  localparam logic [2:0] CFG_OUT_MAX       = 3'd3;
  localparam logic [2:0] CFG_PRESET_SHIFT  = 3'd4;
  localparam logic [2:0] CFG_DIVISOR_SHIFT = 3'd5;

  localparam logic [DivW-1:0] DIVIDER_PTERM = 16'hFFFF;
  localparam int PTermShift = 6;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_ABS  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_FIX  = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic accept;     // item transfer, any kind
    logic mul;        // form Ki*error and error*increment
    logic sum;        // form P term, numerator and undivided increment
    logic abs_load;   // load divider with numerator magnitude
    logic div_step;   // one quotient bit
    logic fix;        // apply signs to quotient and remainder
    logic acc;        // update clamped integral
    logic out_load;   // load result register
  } cmd_t;

  typedef struct packed {
    logic use_div;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/pirdc_ctrl.sv =====
// Sequencer for the PI controller core: steps the datapath through one item.
`timescale 1ns / 1ps
`include "pi_controller_remainder_divide_core_assert.svh"
module pirdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        kind,
  input  pirdc_pkg::status_t status,
  output pirdc_pkg::cmd_t   cmd
);

  pirdc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pirdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == pirdc_pkg::S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.accept   = item_valid && item_ready;
    case (state)
      pirdc_pkg::S_IDLE: begin
        if (item_valid && kind == pirdc_pkg::KIND_STEP) begin
          state_next = pirdc_pkg::S_MUL;
        end
      end
      pirdc_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = pirdc_pkg::S_SUM;
      end
      pirdc_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = status.use_div ? pirdc_pkg::S_ABS : pirdc_pkg::S_ACC;
      end
      pirdc_pkg::S_ABS: begin
        cmd.abs_load = 1'b1;
        state_next   = pirdc_pkg::S_DIV;
      end
      pirdc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = pirdc_pkg::S_FIX;
        end
      end
      pirdc_pkg::S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = pirdc_pkg::S_ACC;
      end
      pirdc_pkg::S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = pirdc_pkg::S_OUT;
      end
      pirdc_pkg::S_OUT: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pirdc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pirdc_pkg::S_IDLE;
      end
    endcase
  end

  `PIRDC_ASSERT(a_step_starts, clk, rst, cmd.accept && kind == pirdc_pkg::KIND_STEP |=> state == pirdc_pkg::S_MUL, "step transfer did not start the sequence")
  `PIRDC_ASSERT(a_fix_after_last, clk, rst, state == pirdc_pkg::S_FIX |-> $past(state) == pirdc_pkg::S_DIV && $past(status.div_last), "sign fix without a finished division")
  `PIRDC_ASSERT(a_abs_only_div, clk, rst, state == pirdc_pkg::S_ABS |-> $past(status.use_div), "divider started on a step that needs no divide")

endmodule

// ===== rtl/core/pirdc_dp.sv =====
// Datapath of the PI controller core: config, multipliers, divider, integral, result.
`timescale 1ns / 1ps
`include "pi_controller_remainder_divide_core_assert.svh"
module pirdc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          kind,
  input  logic signed [15:0]  error_in,
  input  logic [15:0]         divider_in,
  input  logic [15:0]         abs_inc,
  input  logic signed [15:0]  preset_value,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [31:0]  drive_out,
  input  pirdc_pkg::cmd_t     cmd,
  output pirdc_pkg::status_t  status
);

  function automatic logic signed [31:0] clamp_bounds(input logic signed [31:0] v,
                                                      input logic signed [31:0] lo,
                                                      input logic signed [31:0] hi);
    logic signed [31:0] r;
    r = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  // configuration
  logic [15:0]        prop_gain;
  logic [15:0]        integ_gain;
  logic signed [31:0] out_min;
  logic signed [31:0] out_max;
  logic [4:0]         preset_shift;
  logic [3:0]         divisor_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integ_gain    <= '0;
      out_min       <= 32'sh8000_0000;
      out_max       <= 32'sh7FFF_FFFF;
      preset_shift  <= '0;
      divisor_shift <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        pirdc_pkg::CFG_PROP_GAIN:     prop_gain     <= cfg_data[15:0];
        pirdc_pkg::CFG_INTEG_GAIN:    integ_gain    <= cfg_data[15:0];
        pirdc_pkg::CFG_OUT_MIN:       out_min       <= $signed(cfg_data);
        pirdc_pkg::CFG_OUT_MAX:       out_max       <= $signed(cfg_data);
        pirdc_pkg::CFG_PRESET_SHIFT:  preset_shift  <= cfg_data[4:0];
        pirdc_pkg::CFG_DIVISOR_SHIFT: divisor_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [15:0] err;
  logic [15:0]        ainc;
  logic               pterm_sel;
  logic               use_div;
  logic [15:0]        dsor;
  logic               capture;
  logic [15:0]        dshift;

  assign capture = cmd.accept && kind == pirdc_pkg::KIND_STEP;
  assign dshift  = divider_in >> divisor_shift;

  always_ff @(posedge clk) begin
    if (capture) begin
      err       <= error_in;
      ainc      <= abs_inc;
      pterm_sel <= (divider_in == pirdc_pkg::DIVIDER_PTERM);
      use_div   <= (integ_gain != '0) && (divider_in != '0)
                   && (divider_in != pirdc_pkg::DIVIDER_PTERM);
      dsor      <= (dshift == '0) ? 16'd1 : dshift;
    end
  end

  // first multiplier stage
  logic signed [32:0] ki_prod;
  logic signed [32:0] inc_prod;
  logic [31:0]        prod;
  logic [31:0]        scaled;

  assign ki_prod  = $signed({1'b0, integ_gain}) * err;
  assign inc_prod = err * $signed({1'b0, ainc});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod   <= ki_prod[31:0];
      scaled <= inc_prod[31:0];
    end
  end

  // P term, numerator and undivided increment
  logic signed [16:0] rem;
  logic [31:0]        psrc;
  logic [47:0]        pprod;
  logic [31:0]        prop;
  logic [31:0]        num;
  logic [31:0]        diff;

  assign psrc  = pterm_sel ? 32'($signed(scaled) >>> pirdc_pkg::PTermShift)
                           : {{16{err[15]}}, err};
  assign pprod = prop_gain * psrc;

  // divider registers
  logic               neg;
  logic [31:0]        quo;
  logic [15:0]        part;
  logic [pirdc_pkg::StepW-1:0] cnt;
  logic [16:0]        trial;
  logic [16:0]        trial_sub;

  assign trial     = {part, quo[31]};
  assign trial_sub = trial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      prop <= pprod[31:0];
      num  <= prod + {{15{rem[16]}}, rem};
      diff <= (integ_gain != '0) ? prod : '0;
    end else if (cmd.fix) begin
      diff <= neg ? -quo : quo;
    end
    if (cmd.abs_load) begin
      neg  <= num[31];
      quo  <= num[31] ? -num : num;
      part <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      // restoring step: one quotient bit per cycle
      if (trial >= {1'b0, dsor}) begin
        part <= trial_sub[15:0];
        quo  <= {quo[30:0], 1'b1};
      end else begin
        part <= trial[15:0];
        quo  <= {quo[30:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  // integral and remainder state
  logic signed [31:0] integ;
  logic [31:0]        pv32;

  assign pv32 = {{16{preset_value[15]}}, preset_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      rem   <= '0;
    end else begin
      if (cmd.accept && kind == pirdc_pkg::KIND_CLEAR) begin
        integ <= '0;
        rem   <= '0;
      end else if (cmd.accept && kind == pirdc_pkg::KIND_PRESET) begin
        integ <= $signed(pv32 << preset_shift);
      end else if (cmd.acc) begin
        integ <= clamp_bounds($signed(integ + diff), out_min, out_max);
      end
      if (cmd.fix) begin
        rem <= neg ? -$signed({1'b0, part}) : $signed({1'b0, part});
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_out <= clamp_bounds($signed(integ + prop), out_min, out_max);
    end
  end

  assign status.use_div  = use_div;
  assign status.div_last = (cnt == pirdc_pkg::DivLastStep);
  assign status.out_free = !result_valid || result_ready;

  `PIRDC_ASSERT(a_part_below_dsor, clk, rst, cmd.div_step |=> part < dsor, "partial remainder not below divisor")
  `PIRDC_ASSERT(a_integ_bounded, clk, rst, $past(cmd.acc) && out_min <= out_max |-> integ >= out_min && integ <= out_max, "integral outside clamp bounds")
  `PIRDC_ASSERT(a_valid_from_load, clk, rst, $rose(result_valid) |-> $past(cmd.out_load), "result valid without a load")

endmodule

// ===== rtl/core/pi_controller_remainder_divide_core.sv =====
// Top level of the PI controller core with anti-windup clamp and remainder divide.
`timescale 1ns / 1ps
// PI controller with clamped integral. A control step (kind 0) runs the states MUL, SUM,
// ACC and OUT when no integral divide applies, and MUL, SUM, ABS, DIV, FIX, ACC and OUT
// when the increment is divided: the restoring divider produces one quotient bit per cycle.
// OUT loads the result register; the core is ready again in the cycle after that load.
// Clear (kind 1) and preset (kind 2) take effect on their transfer and give no result; the
// next item may follow in the next cycle. One step is in work at a time; a new item is taken
// while the previous result waits in the output register, and a finished step waits until
// that register is free. Configuration must be written through cfg_write_en, cfg_index and
// cfg_data only while the core is idle; the core itself does not enforce this.
module pi_controller_remainder_divide_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         kind,
  input  logic signed [15:0] error_in,
  input  logic [15:0]        divider_in,
  input  logic [15:0]        abs_inc,
  input  logic signed [15:0] preset_value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] drive_out
);

  pirdc_pkg::cmd_t    cmd;
  pirdc_pkg::status_t status;

  pirdc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .status     (status),
    .cmd        (cmd)
  );

  pirdc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .error_in     (error_in),
    .divider_in   (divider_in),
    .abs_inc      (abs_inc),
    .preset_value (preset_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drive_out    (drive_out),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
